// ===== design/cfod_pkg.sv =====
package cfod_pkg;

  // Decoder phase between bytes of one instruction.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIXED,
    PH_ULEB_REG,
    PH_ULEB_DISP
  } phase_t;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
  localparam logic [2:0] ST_TRUNCATED   = 3'd2;
  localparam logic [2:0] ST_BAD_OPERAND = 3'd3;
  localparam logic [2:0] ST_LIMIT       = 3'd4;

  // Operation codes on the result.
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_SAVE      = 3'd1;
  localparam logic [2:0] OP_RESTORE   = 3'd2;
  localparam logic [2:0] OP_SET_FRAME = 3'd3;
  localparam logic [2:0] OP_ALLOC     = 3'd4;

  // Primary opcode classes (top two bits of the opcode byte).
  localparam logic [1:0] PRIM_EXTENDED = 2'b00;
  localparam logic [1:0] PRIM_ADVANCE  = 2'b01;
  localparam logic [1:0] PRIM_SAVE     = 2'b10;
  localparam logic [1:0] PRIM_RESTORE  = 2'b11;

  // Extended opcodes.
  localparam logic [7:0] EXT_NOP       = 8'd0;
  localparam logic [7:0] EXT_SET_LOC   = 8'd1;
  localparam logic [7:0] EXT_ADVANCE1  = 8'd2;
  localparam logic [7:0] EXT_ADVANCE2  = 8'd3;
  localparam logic [7:0] EXT_ADVANCE4  = 8'd4;
  localparam logic [7:0] EXT_SAVE      = 8'd5;
  localparam logic [7:0] EXT_RESTORE   = 8'd10;
  localparam logic [7:0] EXT_DEF_FRAME = 8'd12;
  localparam logic [7:0] EXT_ALLOC     = 8'd14;

  // Configuration register indexes.
  localparam logic CFG_BYTE_ORDER = 1'b0;
  localparam logic CFG_MAX_INSTR  = 1'b1;

  localparam logic [31:0] MAX_INSTR_RESET = 32'd65536;

  // Width of the reported opcode position.
  localparam int POS_OUT_W = 32;

  // One decoded instruction or error report.
  typedef struct packed {
    logic [2:0]           operation;
    logic [31:0]          reg_operand;
    logic [63:0]          operand_offset;
    logic [31:0]          advance_value;
    logic [POS_OUT_W-1:0] instr_position;
    logic [2:0]           status;
    logic                 region_done;
  } result_t;

endpackage

// ===== design/cfod_core.sv =====
module cfod_core import cfod_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          byte_order,
  input  logic [31:0]   max_instructions,
  output logic          res_valid,
  output result_t       res
);

  phase_t                   phase, phase_next;
  logic [7:0]               held_opcode, held_opcode_next;
  logic [63:0]              accumulator, accumulator_next;
  logic [6:0]               shift_amount, shift_amount_next;
  logic [3:0]               bytes_left, bytes_left_next;
  logic [31:0]              held_register, held_register_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] opcode_position, opcode_position_next;
  logic [31:0]              instruction_count, instruction_count_next;
  logic                     dropping, dropping_next;

  logic                     do_finish, do_fail, open_operand;
  logic [2:0]               fail_code, fin_op;
  logic [31:0]              fin_reg, fin_val;
  logic [63:0]              fin_off;
  logic [63:0]              uleb_acc, fixed_acc;
  logic                     uleb_over;
  logic [POS_OUT_W-1:0]     pos_out;

  // Position of the opcode, fitted to the 32-bit result field.
  generate
    if (POSITION_BITS >= POS_OUT_W) begin : g_pos_trunc
      assign pos_out = opcode_position_next[POS_OUT_W-1:0];
    end else begin : g_pos_ext
      assign pos_out = {{(POS_OUT_W-POSITION_BITS){1'b0}}, opcode_position_next};
    end
  endgenerate

  // Operand accumulation for ULEB128 and fixed-width operands.
  always_comb begin
    uleb_over = shift_amount[6] ||
                ((shift_amount[5:0] == 6'd63) && (data_byte[6:1] != 6'd0));
    uleb_acc  = accumulator | ({57'd0, data_byte[6:0]} << shift_amount[5:0]);
    if (byte_order) begin
      fixed_acc = {accumulator[55:0], data_byte};
    end else begin
      fixed_acc = accumulator | ({56'd0, data_byte} << shift_amount[5:0]);
    end
  end

  // Next state and result for the accepted byte.
  always_comb begin
    phase_next             = phase;
    held_opcode_next       = held_opcode;
    accumulator_next       = accumulator;
    shift_amount_next      = shift_amount;
    bytes_left_next        = bytes_left;
    held_register_next     = held_register;
    byte_position_next     = byte_position;
    opcode_position_next   = opcode_position;
    instruction_count_next = instruction_count;
    dropping_next          = dropping;
    do_finish              = 1'b0;
    do_fail                = 1'b0;
    open_operand           = 1'b0;
    fail_code              = ST_OK;
    fin_op                 = OP_NONE;
    fin_reg                = 32'd0;
    fin_off                = 64'd0;
    fin_val                = 32'd0;
    res_valid              = 1'b0;
    res                    = '0;

    if (accept) begin
      byte_position_next = byte_position + {{(POSITION_BITS-1){1'b0}}, 1'b1};

      if (!dropping) begin
        case (phase)
          PH_IDLE: begin
            opcode_position_next = byte_position;
            held_opcode_next     = data_byte;
            case (data_byte[7:6])
              PRIM_ADVANCE: begin
                do_finish = 1'b1;
                fin_val   = {26'd0, data_byte[5:0]};
              end
              PRIM_RESTORE: begin
                do_finish = 1'b1;
                fin_op    = OP_RESTORE;
                fin_reg   = {26'd0, data_byte[5:0]};
              end
              PRIM_SAVE: begin
                held_register_next = {26'd0, data_byte[5:0]};
                accumulator_next   = 64'd0;
                shift_amount_next  = 7'd0;
                phase_next         = PH_ULEB_DISP;
                open_operand       = 1'b1;
              end
              default: begin
                accumulator_next  = 64'd0;
                shift_amount_next = 7'd0;
                case (data_byte)
                  EXT_NOP: do_finish = 1'b1;
                  EXT_SET_LOC: begin
                    bytes_left_next = 4'd8;
                    phase_next      = PH_FIXED;
                    open_operand    = 1'b1;
                  end
                  EXT_ADVANCE1: begin
                    bytes_left_next = 4'd1;
                    phase_next      = PH_FIXED;
                    open_operand    = 1'b1;
                  end
                  EXT_ADVANCE2: begin
                    bytes_left_next = 4'd2;
                    phase_next      = PH_FIXED;
                    open_operand    = 1'b1;
                  end
                  EXT_ADVANCE4: begin
                    bytes_left_next = 4'd4;
                    phase_next      = PH_FIXED;
                    open_operand    = 1'b1;
                  end
                  EXT_SAVE, EXT_DEF_FRAME: begin
                    held_register_next = 32'd0;
                    phase_next         = PH_ULEB_REG;
                    open_operand       = 1'b1;
                  end
                  EXT_RESTORE: begin
                    do_finish = 1'b1;
                    fin_op    = OP_RESTORE;
                  end
                  EXT_ALLOC: begin
                    held_register_next = 32'd0;
                    phase_next         = PH_ULEB_DISP;
                    open_operand       = 1'b1;
                  end
                  default: begin
                    do_fail   = 1'b1;
                    fail_code = ST_UNSUPPORTED;
                  end
                endcase
              end
            endcase
            // An operand that cannot arrive before the region ends.
            if (open_operand && last_byte) begin
              do_fail   = 1'b1;
              fail_code = ST_TRUNCATED;
            end
          end

          PH_FIXED: begin
            accumulator_next  = fixed_acc;
            shift_amount_next = shift_amount + 7'd8;
            bytes_left_next   = bytes_left - 4'd1;
            if (bytes_left == 4'd1) begin
              do_finish = 1'b1;
              if (held_opcode == EXT_SET_LOC) begin
                fin_op  = OP_SET_FRAME;
                fin_off = fixed_acc;
              end else begin
                fin_val = fixed_acc[31:0];
              end
            end else if (last_byte) begin
              do_fail   = 1'b1;
              fail_code = ST_TRUNCATED;
            end
          end

          default: begin
            if (uleb_over) begin
              do_fail   = 1'b1;
              fail_code = ST_BAD_OPERAND;
            end else begin
              accumulator_next  = uleb_acc;
              shift_amount_next = shift_amount + 7'd7;
              if (data_byte[7]) begin
                if (last_byte) begin
                  do_fail   = 1'b1;
                  fail_code = ST_TRUNCATED;
                end
              end else if (phase == PH_ULEB_REG) begin
                // Register operand complete: it must fit in 32 bits.
                if (uleb_acc[63:32] != 32'd0) begin
                  do_fail   = 1'b1;
                  fail_code = ST_BAD_OPERAND;
                end else begin
                  held_register_next = uleb_acc[31:0];
                  accumulator_next   = 64'd0;
                  shift_amount_next  = 7'd0;
                  phase_next         = PH_ULEB_DISP;
                  if (last_byte) begin
                    do_fail   = 1'b1;
                    fail_code = ST_TRUNCATED;
                  end
                end
              end else begin
                do_finish = 1'b1;
                fin_reg   = held_register;
                fin_off   = uleb_acc;
                if ((held_opcode[7:6] == PRIM_SAVE) || (held_opcode == EXT_SAVE)) begin
                  fin_op = OP_SAVE;
                end else if (held_opcode == EXT_DEF_FRAME) begin
                  fin_op = OP_SET_FRAME;
                end else begin
                  fin_op = OP_ALLOC;
                end
              end
            end
          end
        endcase

        // A completed instruction counts against the region limit.
        if (do_finish) begin
          phase_next = PH_IDLE;
          if (instruction_count >= max_instructions) begin
            do_fail   = 1'b1;
            fail_code = ST_LIMIT;
          end else begin
            instruction_count_next = instruction_count + 32'd1;
            res_valid              = 1'b1;
            res.operation          = fin_op;
            res.reg_operand        = fin_reg;
            res.operand_offset     = fin_off;
            res.advance_value      = fin_val;
            res.status             = ST_OK;
          end
        end

        // An error reports once and drops the rest of the region.
        if (do_fail) begin
          phase_next    = PH_IDLE;
          dropping_next = !last_byte;
          res_valid     = 1'b1;
          res           = '0;
          res.status    = fail_code;
        end

        res.instr_position = pos_out;
        res.region_done    = last_byte;
      end

      // The region's last byte restarts the decoder.
      if (last_byte) begin
        phase_next             = PH_IDLE;
        dropping_next          = 1'b0;
        instruction_count_next = 32'd0;
        byte_position_next     = '0;
      end
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      held_opcode       <= 8'd0;
      accumulator       <= 64'd0;
      shift_amount      <= 7'd0;
      bytes_left        <= 4'd0;
      held_register     <= 32'd0;
      byte_position     <= '0;
      opcode_position   <= '0;
      instruction_count <= 32'd0;
      dropping          <= 1'b0;
    end else begin
      phase             <= phase_next;
      held_opcode       <= held_opcode_next;
      accumulator       <= accumulator_next;
      shift_amount      <= shift_amount_next;
      bytes_left        <= bytes_left_next;
      held_register     <= held_register_next;
      byte_position     <= byte_position_next;
      opcode_position   <= opcode_position_next;
      instruction_count <= instruction_count_next;
      dropping          <= dropping_next;
    end
  end

endmodule

// ===== design/call_frame_opcode_decoder.sv =====
// Call-frame instruction decoder. It takes one byte of an instruction region
// per request, with last_byte set on the region's final byte, and gives one
// result per completed instruction or detected error, in byte order. Each byte
// is decoded in the cycle it is accepted, so a new byte can be taken every
// cycle while in_stall is low; the rate is then one byte per clock, set by the
// per-byte update of the phase machine and operand accumulator. A result is
// registered in the output register, or in the skid stage while the output
// is stalled; the two hold up to two results, and in_stall rises only while
// both are occupied. Configuration writes take effect on the next byte and
// should be made only while no region is in progress.
module call_frame_opcode_decoder import cfod_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  operation,
  output logic [31:0] reg_operand,
  output logic [63:0] operand_offset,
  output logic [31:0] advance_value,
  output logic [31:0] instr_position,
  output logic [2:0]  status,
  output logic        region_done
);

  logic        byte_order;
  logic [31:0] max_instructions;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  result_t     skid_res;
  logic        skid_valid;
  logic        out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order       <= 1'b0;
      max_instructions <= MAX_INSTR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BYTE_ORDER: byte_order       <= cfg_data[0];
        CFG_MAX_INSTR:  max_instructions <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  cfod_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .byte_order      (byte_order),
    .max_instructions(max_instructions),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (res_valid) begin
        out_res <= res;
      end
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign operation       = out_res.operation;
  assign reg_operand     = out_res.reg_operand;
  assign operand_offset  = out_res.operand_offset;
  assign advance_value   = out_res.advance_value;
  assign instr_position  = out_res.instr_position;
  assign status          = out_res.status;
  assign region_done     = out_res.region_done;

endmodule
